[sv/grbi_pkg.sv]
`timescale 1ns / 1ps
// Package for the gyro rate biquad integrator.
// Holds widths, register indexes, controller types and the Q29 saturation helper.
package grbi_pkg;

	localparam int CAL_SAMPLES = 1000;
	localparam int SAMPLE_W    = 16;

	localparam int RAW_W       = 16;
	localparam int SCALE_W     = 16;
	localparam int COEF_W      = 19;
	localparam int TSTEP_W     = 24;
	localparam int RATE_W      = 29;
	localparam int HEAD_W      = 32;
	localparam int CAL_SUM_W   = 40;
	localparam int CAL_CNT_W   = 10;
	localparam int DIV_SLICE_W = 13;
	localparam int DIV_SLICES  = 4;
	localparam int DIV_CNT_W   = $clog2(DIV_SLICES);
	localparam int DIV_K       = CAL_SUM_W + CAL_CNT_W;
	localparam int DIV_SHIFT   = DIV_K - (DIV_SLICES - 1) * DIV_SLICE_W;
	localparam int DIV_ACC_W   = CAL_SUM_W + DIV_SLICE_W + 1;
	localparam int DIV_RCP_W   = DIV_SLICES * DIV_SLICE_W;
	localparam int MUL_A_W     = 29;
	localparam int MUL_B_W     = 25;
	localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
	localparam int ACC_W       = 36;
	localparam int MAC_TAPS    = 5;
	localparam int TAP_W       = 3;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 24;

	// ceil(2^DIV_K / CAL_SAMPLES): exact truncated quotient for any 40-bit magnitude
	localparam logic [DIV_RCP_W-1:0] DIV_RECIP = DIV_RCP_W'(((64'd1 << DIV_K)
		+ 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));

	localparam logic [CFG_IDX_W-1:0] REG_SCALE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_B0    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_B1    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_B2    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_A1    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_A2    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_TSTEP = 3'd6;

	localparam logic [SCALE_W-1:0]        SCALE_RST = 16'd3996;
	localparam logic signed [COEF_W-1:0]  B0_RST    = 19'sd65536;
	localparam logic [TSTEP_W-1:0]        TSTEP_RST = 24'd16777;

	localparam logic signed [RATE_W-1:0] Q29_MAX = 29'sh0FFF_FFFF;
	localparam logic signed [RATE_W-1:0] Q29_MIN = 29'sh1000_0000;
	localparam logic signed [HEAD_W-1:0] Q32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [HEAD_W-1:0] Q32_MIN = 32'sh8000_0000;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCALE,
		S_PREP,
		S_DIV,
		S_DIVEND,
		S_MAC,
		S_MACEND,
		S_YSAT,
		S_YAWMUL,
		S_YAW,
		S_OUT
	} st_t;

	typedef enum logic [2:0] {
		MS_SCALE,
		MS_B0,
		MS_B1,
		MS_B2,
		MS_A1,
		MS_A2,
		MS_TSTEP
	} mul_sel_t;

	typedef struct packed {
		logic     ld_in;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     prep;
		logic     cal_end;
		logic     acc_clr;
		logic     acc_add;
		logic     ld_y;
		logic     yaw_upd;
		logic     load_out;
	} cmd_t;

	typedef struct packed {
		logic mode;
		logic cal_hit;
		logic div_done;
		logic out_busy;
	} stat_t;

	function automatic logic signed [RATE_W-1:0] sat_q29(input logic signed [40:0] v);
		logic signed [RATE_W-1:0] r;
		if (v > 41'(Q29_MAX))
			r = Q29_MAX;
		else if (v < 41'(Q29_MIN))
			r = Q29_MIN;
		else
			r = v[RATE_W-1:0];
		return r;
	endfunction

endpackage

[sv/grbi_in_if.sv]
`timescale 1ns / 1ps
// Input channel: one gyro sample word with its mode bit.
// Uses grbi_pkg for field widths.
interface grbi_in_if;
	import grbi_pkg::*;

	logic                     valid;
	logic                     ready;
	logic                     mode;
	logic signed [RAW_W-1:0]  raw_rate;

	modport source (output valid, output mode, output raw_rate, input ready);
	modport sink   (input valid, input mode, input raw_rate, output ready);
endinterface

[sv/grbi_out_if.sv]
`timescale 1ns / 1ps
// Output channel: filtered rate, heading and calibration flag per word.
// Uses grbi_pkg for field widths.
interface grbi_out_if;
	import grbi_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [RATE_W-1:0]  filtered_rate;
	logic signed [HEAD_W-1:0]  heading;
	logic                      cal_done;

	modport source (output valid, output filtered_rate, output heading, output cal_done,
		input ready);
	modport sink   (input valid, input filtered_rate, input heading, input cal_done,
		output ready);
endinterface

[sv/gyro_rate_biquad_integrator.sv]
`timescale 1ns / 1ps
// Top level of the gyro rate biquad integrator: controller plus datapath.
// Depends on grbi_pkg, grbi_in_if, grbi_out_if, grbi_ctrl and grbi_dp.
//
//  channel  dir  fields                                  handshake
//  sample   in   mode, raw_rate                          valid/ready
//  result   out  filtered_rate, heading, cal_done        valid/ready
//  cfg      in   cfg_index, cfg_data                     cfg_we, no wait
//
// A sample is taken only in the idle state, once the last result is loaded into
// the output register; one shared 29x25 multiplier runs scaling, five filter
// taps and the yaw product in turn.
// The word that completes calibration waits for the divider, the offset coming
// from a reciprocal product in four 13-bit slices.
// Reset asynchronously clears config, filter and yaw state; no clearing pass needed.
// A pending result word holds in the output register while the next sample is
// taken; the sequence stalls only when it must write a new result over it.
module gyro_rate_biquad_integrator import grbi_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	grbi_in_if.sink                sample,
	grbi_out_if.source             result
);

	cmd_t  cmd;
	stat_t stat;

	grbi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.in_ready (sample.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	grbi_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_mode   (sample.mode),
		.in_raw    (sample.raw_rate),
		.cmd       (cmd),
		.stat      (stat),
		.out_ready (result.ready),
		.out_valid (result.valid),
		.out_rate  (result.filtered_rate),
		.out_head  (result.heading),
		.out_done  (result.cal_done)
	);

endmodule

[sv/grbi_div.sv]
`timescale 1ns / 1ps
// Division of the calibration sum by CAL_SAMPLES through a reciprocal product,
// one 13-bit slice of the reciprocal a cycle. Depends on grbi_pkg; rounds toward zero.
module grbi_div import grbi_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic signed [CAL_SUM_W-1:0]  dividend,
	output logic                         done,
	output logic signed [RATE_W-1:0]     quot
);

	logic                    busy_q;
	logic                    done_q;
	logic                    neg_q;
	logic [DIV_CNT_W-1:0]    cnt_q;
	logic [CAL_SUM_W-1:0]    mag_q;
	logic [DIV_ACC_W-1:0]    acc_q;
	logic [DIV_SLICE_W-1:0]  slice;
	logic [DIV_ACC_W-1:0]    part;
	logic [DIV_ACC_W-1:0]    carry_in;
	logic [CAL_SUM_W-1:0]    mag;
	logic [CAL_SUM_W-1:0]    mag_quot;
	logic signed [40:0]      signed_q;

	assign mag = dividend[CAL_SUM_W-1] ? (~dividend + 1'b1) : dividend;

	always_comb begin
		slice = '0;
		for (int i = 0; i < DIV_SLICES; i++)
			if (cnt_q == DIV_CNT_W'(i))
				slice = DIV_RECIP[i*DIV_SLICE_W +: DIV_SLICE_W];
	end

	// drop the low slice bits of the running sum before adding the next partial product
	assign part     = DIV_ACC_W'(mag_q) * DIV_ACC_W'(slice);
	assign carry_in = (cnt_q == '0) ? '0 : (acc_q >> DIV_SLICE_W);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_SLICES - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[CAL_SUM_W-1];
			mag_q <= mag;
		end else if (busy_q) begin
			acc_q <= carry_in + part;
		end
	end

	assign mag_quot = acc_q[DIV_SHIFT +: CAL_SUM_W];
	assign signed_q = neg_q ? -41'({1'b0, mag_quot}) : 41'({1'b0, mag_quot});
	assign quot     = sat_q29(signed_q);
	assign done     = done_q;

endmodule

[sv/grbi_dp.sv]
`timescale 1ns / 1ps
// Datapath: config registers, shared multiplier, accumulator, filter and yaw state.
// Depends on grbi_pkg and grbi_div; driven by grbi_ctrl commands.
module grbi_dp import grbi_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data,
	input  logic                          in_mode,
	input  logic signed [RAW_W-1:0]       in_raw,
	input  cmd_t                          cmd,
	output stat_t                         stat,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic signed [RATE_W-1:0]      out_rate,
	output logic signed [HEAD_W-1:0]      out_head,
	output logic                          out_done
);

	logic [SCALE_W-1:0]         scale_q;
	logic signed [COEF_W-1:0]   b0_q, b1_q, b2_q, a1_q, a2_q;
	logic [TSTEP_W-1:0]         tstep_q;

	logic                       mode_q;
	logic [RAW_W-1:0]           sample_q;
	logic signed [MUL_P_W-1:0]  prod_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [RATE_W-1:0]   x_q;
	logic signed [RATE_W-1:0]   y_q;
	logic signed [RATE_W-1:0]   in_hist_q [2];
	logic signed [RATE_W-1:0]   out_hist_q [2];
	logic signed [RATE_W-1:0]   offset_q;
	logic signed [CAL_SUM_W-1:0] cal_sum_q;
	logic [CAL_CNT_W-1:0]       cal_count_q;
	logic signed [HEAD_W-1:0]   yaw_q;
	logic                       done_q;
	logic                       out_vld_q;
	logic signed [RATE_W-1:0]   out_rate_q;
	logic signed [HEAD_W-1:0]   out_head_q;
	logic                       out_done_q;

	logic signed [MUL_A_W-1:0]  mul_a;
	logic signed [MUL_B_W-1:0]  mul_b;
	logic signed [MUL_P_W-1:0]  mul_p;
	logic signed [RATE_W-1:0]   sample_ext;
	logic signed [RATE_W-1:0]   scaled;
	logic signed [RATE_W:0]     diff;
	logic signed [ACC_W-1:0]    term;
	logic signed [RATE_W:0]     yaw_inc;
	logic signed [HEAD_W:0]     yaw_sum;
	logic signed [HEAD_W-1:0]   yaw_sat;
	logic signed [CAL_SUM_W-1:0] new_sum;
	logic [CAL_CNT_W-1:0]       cnt_next;
	logic                       cal_hit;
	logic                       div_start;
	logic                       div_done;
	logic signed [RATE_W-1:0]   div_quot;
	logic signed [RATE_W-1:0]   y_next;

	assign sample_ext = RATE_W'(signed'(sample_q[SAMPLE_W-1:0]));

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.mul_sel)
			MS_SCALE: begin
				mul_a = sample_ext;
				mul_b = MUL_B_W'({1'b0, scale_q});
			end
			MS_B0: begin
				mul_a = x_q;
				mul_b = MUL_B_W'(b0_q);
			end
			MS_B1: begin
				mul_a = in_hist_q[0];
				mul_b = MUL_B_W'(b1_q);
			end
			MS_B2: begin
				mul_a = in_hist_q[1];
				mul_b = MUL_B_W'(b2_q);
			end
			MS_A1: begin
				mul_a = out_hist_q[0];
				mul_b = MUL_B_W'(a1_q);
			end
			MS_A2: begin
				mul_a = out_hist_q[1];
				mul_b = MUL_B_W'(a2_q);
			end
			MS_TSTEP: begin
				mul_a = y_q;
				mul_b = MUL_B_W'({1'b0, tstep_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p    = mul_a * mul_b;
	assign scaled   = sat_q29(41'(signed'(prod_q[32:0])));
	assign diff     = (RATE_W+1)'(scaled) - (RATE_W+1)'(offset_q);
	assign term     = signed'(prod_q[ACC_W+15:16]);
	assign yaw_inc  = signed'(prod_q[MUL_P_W-1:24]);
	assign yaw_sum  = (HEAD_W+1)'(yaw_q) + (HEAD_W+1)'(yaw_inc);
	assign yaw_sat  = (yaw_sum > (HEAD_W+1)'(Q32_MAX)) ? Q32_MAX :
		(yaw_sum < (HEAD_W+1)'(Q32_MIN)) ? Q32_MIN : yaw_sum[HEAD_W-1:0];
	assign new_sum  = cal_sum_q + CAL_SUM_W'(scaled);
	assign cnt_next = cal_count_q + 1'b1;
	assign cal_hit  = cnt_next >= CAL_CNT_W'(CAL_SAMPLES);
	assign div_start = cmd.prep && !mode_q && cal_hit;
	assign y_next   = sat_q29(41'(acc_q));

	grbi_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (new_sum),
		.done     (div_done),
		.quot     (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q       <= SCALE_RST;
			b0_q          <= B0_RST;
			b1_q          <= '0;
			b2_q          <= '0;
			a1_q          <= '0;
			a2_q          <= '0;
			tstep_q       <= TSTEP_RST;
			cal_sum_q     <= '0;
			cal_count_q   <= '0;
			offset_q      <= '0;
			in_hist_q[0]  <= '0;
			in_hist_q[1]  <= '0;
			out_hist_q[0] <= '0;
			out_hist_q[1] <= '0;
			yaw_q         <= '0;
			done_q        <= 1'b0;
			out_vld_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_SCALE: scale_q <= cfg_data[SCALE_W-1:0];
					REG_B0:    b0_q    <= signed'(cfg_data[COEF_W-1:0]);
					REG_B1:    b1_q    <= signed'(cfg_data[COEF_W-1:0]);
					REG_B2:    b2_q    <= signed'(cfg_data[COEF_W-1:0]);
					REG_A1:    a1_q    <= signed'(cfg_data[COEF_W-1:0]);
					REG_A2:    a2_q    <= signed'(cfg_data[COEF_W-1:0]);
					REG_TSTEP: tstep_q <= cfg_data[TSTEP_W-1:0];
					default: ;
				endcase
			end
			if (cmd.ld_in)
				done_q <= 1'b0;
			if (cmd.prep && !mode_q) begin
				cal_sum_q   <= cal_hit ? '0 : new_sum;
				cal_count_q <= cal_hit ? '0 : cnt_next;
			end
			if (cmd.cal_end) begin
				offset_q      <= div_quot;
				in_hist_q[0]  <= '0;
				in_hist_q[1]  <= '0;
				out_hist_q[0] <= '0;
				out_hist_q[1] <= '0;
				done_q        <= 1'b1;
			end
			if (cmd.ld_y) begin
				in_hist_q[1]  <= in_hist_q[0];
				in_hist_q[0]  <= x_q;
				out_hist_q[1] <= out_hist_q[0];
				out_hist_q[0] <= y_next;
			end
			if (cmd.yaw_upd)
				yaw_q <= yaw_sat;
			if (cmd.load_out)
				out_vld_q <= 1'b1;
			else if (out_ready)
				out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			mode_q   <= in_mode;
			sample_q <= in_raw;
		end
		if (cmd.mul_en)
			prod_q <= mul_p;
		if (cmd.prep)
			x_q <= sat_q29(41'(diff));
		if (cmd.acc_clr)
			acc_q <= '0;
		else if (cmd.acc_add)
			acc_q <= acc_q + term;
		if (cmd.ld_y)
			y_q <= y_next;
		if (cmd.load_out) begin
			out_rate_q <= mode_q ? y_q : '0;
			out_head_q <= yaw_q;
			out_done_q <= done_q;
		end
	end

	assign stat.mode     = mode_q;
	assign stat.cal_hit  = cal_hit;
	assign stat.div_done = div_done;
	assign stat.out_busy = out_vld_q && !out_ready;

	assign out_valid = out_vld_q;
	assign out_rate  = out_rate_q;
	assign out_head  = out_head_q;
	assign out_done  = out_done_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !(out_vld_q && !out_ready))
		else $error("result word overwritten while pending");

	a_hist_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cal_end |=> (in_hist_q[0] == '0 && in_hist_q[1] == '0 &&
			out_hist_q[0] == '0 && out_hist_q[1] == '0))
		else $error("filter history not cleared after calibration");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cal_count_q < CAL_CNT_W'(CAL_SAMPLES))
		else $error("calibration count out of range");

	a_div_latency: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> !div_done)
		else $error("divider finished too early");

endmodule

[sv/grbi_ctrl.sv]
`timescale 1ns / 1ps
// Controller: sequences one sample through scaling, then calibration or filter and yaw.
// Depends on grbi_pkg; drives grbi_dp through cmd_t, reads stat_t.
module grbi_ctrl import grbi_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  stat_t  stat,
	output cmd_t   cmd
);

	st_t             state_q, state_d;
	logic [TAP_W-1:0] tap_q, tap_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tap_q   <= '0;
		end else begin
			state_q <= state_d;
			tap_q   <= tap_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		tap_d    = tap_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.mul_sel = MS_SCALE;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.ld_in = 1'b1;
					state_d   = S_SCALE;
				end
			end
			S_SCALE: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_SCALE;
				state_d     = S_PREP;
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				tap_d    = '0;
				if (stat.mode)
					state_d = S_MAC;
				else if (stat.cal_hit)
					state_d = S_DIV;
				else
					state_d = S_OUT;
			end
			S_DIV: begin
				if (stat.div_done)
					state_d = S_DIVEND;
			end
			S_DIVEND: begin
				cmd.cal_end = 1'b1;
				state_d     = S_OUT;
			end
			S_MAC: begin
				cmd.mul_en = 1'b1;
				unique case (tap_q)
					3'd0:    cmd.mul_sel = MS_B0;
					3'd1:    cmd.mul_sel = MS_B1;
					3'd2:    cmd.mul_sel = MS_B2;
					3'd3:    cmd.mul_sel = MS_A1;
					default: cmd.mul_sel = MS_A2;
				endcase
				if (tap_q == '0)
					cmd.acc_clr = 1'b1;
				else
					cmd.acc_add = 1'b1;
				tap_d = tap_q + 1'b1;
				if (tap_q == TAP_W'(MAC_TAPS - 1))
					state_d = S_MACEND;
			end
			S_MACEND: begin
				cmd.acc_add = 1'b1;
				state_d     = S_YSAT;
			end
			S_YSAT: begin
				cmd.ld_y = 1'b1;
				state_d  = S_YAWMUL;
			end
			S_YAWMUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_TSTEP;
				state_d     = S_YAW;
			end
			S_YAW: begin
				cmd.yaw_upd = 1'b1;
				state_d     = S_OUT;
			end
			S_OUT: begin
				if (!stat.out_busy) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	a_mac_taps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MAC) |-> (tap_q < TAP_W'(MAC_TAPS)))
		else $error("filter tap counter out of range");

	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PREP && !stat.mode && stat.cal_hit) |=> (state_q == S_DIV))
		else $error("completed calibration did not start the divider");

	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ld_in |=> (state_q == S_SCALE))
		else $error("accepted word did not start the sequence");

endmodule
